### design/vmmio_pkg.sv
// Shared types and constants for the virtio MMIO register block.
package vmmio_pkg;

  // Transaction payloads
  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] offset;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_ok;
    logic        irq_level;
    logic        notify_valid;
    logic [31:0] notify_queue;
  } out_item_t;

  // Operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_LO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_HI   = 2'd2;

  // Register map
  localparam logic [11:0] OFF_MAGIC         = 12'h000;
  localparam logic [11:0] OFF_VERSION       = 12'h004;
  localparam logic [11:0] OFF_DEVICE_ID     = 12'h008;
  localparam logic [11:0] OFF_VENDOR_ID     = 12'h00c;
  localparam logic [11:0] OFF_DEV_FEAT      = 12'h010;
  localparam logic [11:0] OFF_DEV_FEAT_SEL  = 12'h014;
  localparam logic [11:0] OFF_DRV_FEAT      = 12'h020;
  localparam logic [11:0] OFF_DRV_FEAT_SEL  = 12'h024;
  localparam logic [11:0] OFF_QUEUE_SEL     = 12'h030;
  localparam logic [11:0] OFF_QUEUE_NUM_MAX = 12'h034;
  localparam logic [11:0] OFF_QUEUE_NUM     = 12'h038;
  localparam logic [11:0] OFF_QUEUE_READY   = 12'h044;
  localparam logic [11:0] OFF_QUEUE_NOTIFY  = 12'h050;
  localparam logic [11:0] OFF_INT_STATUS    = 12'h060;
  localparam logic [11:0] OFF_INT_ACK       = 12'h064;
  localparam logic [11:0] OFF_STATUS        = 12'h070;
  localparam logic [11:0] OFF_DESC_LO       = 12'h080;
  localparam logic [11:0] OFF_DESC_HI       = 12'h084;
  localparam logic [11:0] OFF_AVAIL_LO      = 12'h090;
  localparam logic [11:0] OFF_AVAIL_HI      = 12'h094;
  localparam logic [11:0] OFF_USED_LO       = 12'h0a0;
  localparam logic [11:0] OFF_USED_HI       = 12'h0a4;
  localparam logic [11:0] OFF_CONFIG_GEN    = 12'h0fc;

  // Fixed read values
  localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
  localparam logic [31:0] VERSION_VALUE = 32'h0000_0002;
  localparam logic [31:0] VENDOR_VALUE  = 32'h0000_1af4;

  // Parameter defaults
  localparam int unsigned NUM_QUEUES_DEF     = 2;
  localparam int unsigned QUEUE_SIZE_MAX_DEF = 256;

endpackage

### design/virtio_mmio_register_block.sv
// Top level: register face of a version 2 virtio MMIO transport.
// A transaction is held in the input register, its result in the output register.
// Throughput: one transaction per cycle; while a stalled result waits in the output
// register the input register takes one more transaction, then the input stalls.
// Reset (rst_n low, synchronous): all device, driver and queue state clears to
// zero, configuration registers clear to zero, both pipeline registers empty.
module virtio_mmio_register_block #(
  parameter int unsigned NUM_QUEUES     = vmmio_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_SIZE_MAX = vmmio_pkg::QUEUE_SIZE_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [vmmio_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  // bus access / event transactions
  input  logic                           in_valid,
  output logic                           in_stall,
  input  vmmio_pkg::in_item_t            in_data,
  // result transactions
  output logic                           out_valid,
  input  logic                           out_stall,
  output vmmio_pkg::out_item_t           out_data
);

  localparam int unsigned QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  // Configuration registers
  logic [31:0] device_id_r;
  logic [31:0] feat_lo_r;
  logic [31:0] feat_hi_r;

  // Device and driver state
  logic        feat_sel_r,     feat_sel_nxt;
  logic [31:0] drv_feat_r,     drv_feat_nxt;
  logic [31:0] drv_feat_sel_r, drv_feat_sel_nxt;
  logic [31:0] sel_queue_r,    sel_queue_nxt;
  logic [31:0] int_status_r,   int_status_nxt;
  logic [31:0] dev_status_r,   dev_status_nxt;

  // Per-queue state
  logic [15:0] qsize_r  [NUM_QUEUES];
  logic [15:0] qsize_nxt[NUM_QUEUES];
  logic        qready_r  [NUM_QUEUES];
  logic        qready_nxt[NUM_QUEUES];
  logic [63:0] qdesc_r  [NUM_QUEUES];
  logic [63:0] qdesc_nxt[NUM_QUEUES];
  logic [63:0] qavail_r  [NUM_QUEUES];
  logic [63:0] qavail_nxt[NUM_QUEUES];
  logic [63:0] qused_r  [NUM_QUEUES];
  logic [63:0] qused_nxt[NUM_QUEUES];

  // Pipeline registers
  logic                 in_valid_r;
  vmmio_pkg::in_item_t  in_item_r;
  logic                 out_valid_r;
  vmmio_pkg::out_item_t out_item_r;
  vmmio_pkg::out_item_t result;

  logic              advance;
  logic              in_accept;
  logic              q_in_range;
  logic [QIDX_W-1:0] q_idx;
  logic [15:0]       qsize_wr;

  // Move the held transaction into the output register unless the result
  // already there is being held back by the consumer.
  assign advance   = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Queue selection; an out-of-range selection turns per-queue writes off
  assign q_in_range = sel_queue_r < 32'(NUM_QUEUES);
  assign q_idx      = sel_queue_r[QIDX_W-1:0];
  assign qsize_wr   = (in_item_r.write_data > 32'(QUEUE_SIZE_MAX)) ?
                      16'(QUEUE_SIZE_MAX) : in_item_r.write_data[15:0];

  // Decode the held transaction: result fields and next state
  always_comb begin
    feat_sel_nxt     = feat_sel_r;
    drv_feat_nxt     = drv_feat_r;
    drv_feat_sel_nxt = drv_feat_sel_r;
    sel_queue_nxt    = sel_queue_r;
    int_status_nxt   = int_status_r;
    dev_status_nxt   = dev_status_r;
    qsize_nxt        = qsize_r;
    qready_nxt       = qready_r;
    qdesc_nxt        = qdesc_r;
    qavail_nxt       = qavail_r;
    qused_nxt        = qused_r;

    result              = '0;

    case (in_item_r.op)
      vmmio_pkg::OP_READ: begin
        result.access_ok = 1'b1;
        case (in_item_r.offset)
          vmmio_pkg::OFF_MAGIC:         result.read_data = vmmio_pkg::MAGIC_VALUE;
          vmmio_pkg::OFF_VERSION:       result.read_data = vmmio_pkg::VERSION_VALUE;
          vmmio_pkg::OFF_DEVICE_ID:     result.read_data = device_id_r;
          vmmio_pkg::OFF_VENDOR_ID:     result.read_data = vmmio_pkg::VENDOR_VALUE;
          vmmio_pkg::OFF_DEV_FEAT:      result.read_data = feat_sel_r ? feat_hi_r : feat_lo_r;
          vmmio_pkg::OFF_QUEUE_NUM_MAX:
            result.read_data = q_in_range ? 32'(QUEUE_SIZE_MAX) : 32'd0;
          vmmio_pkg::OFF_QUEUE_READY:
            result.read_data = q_in_range ? 32'(qready_r[q_idx]) : 32'd0;
          vmmio_pkg::OFF_INT_STATUS:    result.read_data = int_status_r;
          vmmio_pkg::OFF_STATUS:        result.read_data = dev_status_r;
          vmmio_pkg::OFF_CONFIG_GEN:    result.read_data = 32'd0;
          default:                      result.access_ok = 1'b0;
        endcase
      end

      vmmio_pkg::OP_WRITE: begin
        result.access_ok = 1'b1;
        case (in_item_r.offset)
          vmmio_pkg::OFF_DEV_FEAT_SEL: feat_sel_nxt     = in_item_r.write_data[0];
          vmmio_pkg::OFF_DRV_FEAT:     drv_feat_nxt     = in_item_r.write_data;
          vmmio_pkg::OFF_DRV_FEAT_SEL: drv_feat_sel_nxt = in_item_r.write_data;
          vmmio_pkg::OFF_QUEUE_SEL:    sel_queue_nxt    = in_item_r.write_data;
          vmmio_pkg::OFF_QUEUE_NUM: begin
            if (q_in_range) qsize_nxt[q_idx] = qsize_wr;
          end
          vmmio_pkg::OFF_QUEUE_READY: begin
            if (q_in_range) qready_nxt[q_idx] = (in_item_r.write_data == 32'd1);
          end
          vmmio_pkg::OFF_DESC_LO: begin
            if (q_in_range) qdesc_nxt[q_idx][31:0] = in_item_r.write_data;
          end
          vmmio_pkg::OFF_DESC_HI: begin
            if (q_in_range) qdesc_nxt[q_idx][63:32] = in_item_r.write_data;
          end
          vmmio_pkg::OFF_AVAIL_LO: begin
            if (q_in_range) qavail_nxt[q_idx][31:0] = in_item_r.write_data;
          end
          vmmio_pkg::OFF_AVAIL_HI: begin
            if (q_in_range) qavail_nxt[q_idx][63:32] = in_item_r.write_data;
          end
          vmmio_pkg::OFF_USED_LO: begin
            if (q_in_range) qused_nxt[q_idx][31:0] = in_item_r.write_data;
          end
          vmmio_pkg::OFF_USED_HI: begin
            if (q_in_range) qused_nxt[q_idx][63:32] = in_item_r.write_data;
          end
          vmmio_pkg::OFF_QUEUE_NOTIFY: begin
            // pass the queue index out for any value, in range or not
            result.notify_valid = 1'b1;
            result.notify_queue = in_item_r.write_data;
          end
          vmmio_pkg::OFF_INT_ACK: int_status_nxt = int_status_r & ~in_item_r.write_data;
          vmmio_pkg::OFF_STATUS: begin
            dev_status_nxt = in_item_r.write_data;
            // device reset: drop driver features and every queue setting
            if (in_item_r.write_data == 32'd0) begin
              drv_feat_nxt     = '0;
              drv_feat_sel_nxt = '0;
              for (int i = 0; i < NUM_QUEUES; i++) begin
                qsize_nxt[i]  = '0;
                qready_nxt[i] = 1'b0;
                qdesc_nxt[i]  = '0;
                qavail_nxt[i] = '0;
                qused_nxt[i]  = '0;
              end
            end
          end
          default: result.access_ok = 1'b0;
        endcase
      end

      vmmio_pkg::OP_EVENT: begin
        // request completion raises the used-buffer interrupt
        result.access_ok = 1'b1;
        int_status_nxt   = int_status_r | 32'd1;
      end

      default: result.access_ok = 1'b0;
    endcase

    // line level reflects status after this transaction
    result.irq_level = (int_status_nxt != 32'd0);
  end

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= '0;
      feat_lo_r   <= '0;
      feat_hi_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vmmio_pkg::CFG_DEVICE_ID: device_id_r <= cfg_wdata;
        vmmio_pkg::CFG_FEAT_LO:   feat_lo_r   <= cfg_wdata;
        vmmio_pkg::CFG_FEAT_HI:   feat_hi_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept)    in_valid_r <= 1'b1;
      else if (advance) in_valid_r <= 1'b0;

      if (advance)         out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Pipeline payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_accept) in_item_r  <= in_data;
    if (advance)   out_item_r <= result;
  end

  // Architectural state: update only when a transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feat_sel_r     <= 1'b0;
      drv_feat_r     <= '0;
      drv_feat_sel_r <= '0;
      sel_queue_r    <= '0;
      int_status_r   <= '0;
      dev_status_r   <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        qsize_r[i]  <= '0;
        qready_r[i] <= 1'b0;
        qdesc_r[i]  <= '0;
        qavail_r[i] <= '0;
        qused_r[i]  <= '0;
      end
    end else if (advance) begin
      feat_sel_r     <= feat_sel_nxt;
      drv_feat_r     <= drv_feat_nxt;
      drv_feat_sel_r <= drv_feat_sel_nxt;
      sel_queue_r    <= sel_queue_nxt;
      int_status_r   <= int_status_nxt;
      dev_status_r   <= dev_status_nxt;
      qsize_r        <= qsize_nxt;
      qready_r       <= qready_nxt;
      qdesc_r        <= qdesc_nxt;
      qavail_r       <= qavail_nxt;
      qused_r        <= qused_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A held result's interrupt level matches the live interrupt status
  a_irq_tracks_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.irq_level == (int_status_r != 32'd0)))
    else $error("irq_level disagrees with interrupt status");

  // A notify is always a successful write
  a_notify_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.notify_valid) |-> out_item_r.access_ok)
    else $error("notify reported on a failed access");

  // Status write of zero clears the driver feature word and its select
  a_status_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.op == vmmio_pkg::OP_WRITE &&
     in_item_r.offset == vmmio_pkg::OFF_STATUS && in_item_r.write_data == 32'd0)
    |=> (drv_feat_r == 32'd0 && drv_feat_sel_r == 32'd0))
    else $error("device reset left driver features set");

  // Stored size of queue 0 never exceeds the maximum
  a_qsize_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(qsize_r[0]) <= 32'(QUEUE_SIZE_MAX))
    else $error("queue size above maximum");
`endif

endmodule

### tb/testbench.sv
// Testbench for the virtio MMIO register block: directed and random bus traffic.
module testbench;

  localparam int unsigned NUM_Q     = vmmio_pkg::NUM_QUEUES_DEF;
  localparam int unsigned QSIZE_MAX = vmmio_pkg::QUEUE_SIZE_MAX_DEF;
  localparam int unsigned DRAIN_LIMIT = 2000;
  // unused operation code, rejected by the block
  localparam logic [1:0]  OP_RESERVED = 2'd3;

  // DUT inputs start known at time zero
  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [vmmio_pkg::CFG_IDX_W-1:0] cfg_index  = vmmio_pkg::CFG_DEVICE_ID;
  logic [31:0]                     cfg_wdata  = '0;
  logic                            in_valid   = 1'b0;
  vmmio_pkg::in_item_t             in_data    = '0;
  logic                            out_stall  = 1'b0;
  logic                            in_stall;
  logic                            out_valid;
  vmmio_pkg::out_item_t            out_data;

  virtio_mmio_register_block #(
    .NUM_QUEUES     (NUM_Q),
    .QUEUE_SIZE_MAX (QSIZE_MAX)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial forever #5 clk = ~clk;

  // Hard stop: far beyond the slowest legal run (every transaction behind the
  // longest sender gap and the longest receiver stall).
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the device as the driver sees it.
  // Queue sizes, ring addresses and driver features are write-only on this
  // interface, so only their access answer is predicted; the queue ready flag
  // reads back and is tracked per queue.
  // ---------------------------------------------------------------------------
  logic [31:0] dev_id_cfg;
  logic [31:0] feat_lo_cfg;
  logic [31:0] feat_hi_cfg;
  logic        feat_sel;
  logic [31:0] queue_sel;
  logic [31:0] irq_status;
  logic [31:0] dev_status;
  logic        q_ready [NUM_Q];

  vmmio_pkg::out_item_t expected_responses [$];
  int unsigned error_count = 0;

  // Sender burst shaping and receiver stall pattern
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;
  int unsigned stall_tick = 0;

  logic [11:0] reg_offsets [0:22] = '{
    vmmio_pkg::OFF_MAGIC, vmmio_pkg::OFF_VERSION, vmmio_pkg::OFF_DEVICE_ID,
    vmmio_pkg::OFF_VENDOR_ID, vmmio_pkg::OFF_DEV_FEAT, vmmio_pkg::OFF_DEV_FEAT_SEL,
    vmmio_pkg::OFF_DRV_FEAT, vmmio_pkg::OFF_DRV_FEAT_SEL, vmmio_pkg::OFF_QUEUE_SEL,
    vmmio_pkg::OFF_QUEUE_NUM_MAX, vmmio_pkg::OFF_QUEUE_NUM, vmmio_pkg::OFF_QUEUE_READY,
    vmmio_pkg::OFF_QUEUE_NOTIFY, vmmio_pkg::OFF_INT_STATUS, vmmio_pkg::OFF_INT_ACK,
    vmmio_pkg::OFF_STATUS, vmmio_pkg::OFF_DESC_LO, vmmio_pkg::OFF_DESC_HI,
    vmmio_pkg::OFF_AVAIL_LO, vmmio_pkg::OFF_AVAIL_HI, vmmio_pkg::OFF_USED_LO,
    vmmio_pkg::OFF_USED_HI, vmmio_pkg::OFF_CONFIG_GEN
  };

  initial begin
    feat_sel    = 1'b0;
    queue_sel   = '0;
    irq_status  = '0;
    dev_status  = '0;
    dev_id_cfg  = '0;
    feat_lo_cfg = '0;
    feat_hi_cfg = '0;
    foreach (q_ready[i]) q_ready[i] = 1'b0;
  end

  // Work out the answer to one bus access and advance the device copy.
  function automatic vmmio_pkg::out_item_t predict_register_access(vmmio_pkg::in_item_t acc);
    vmmio_pkg::out_item_t r;
    logic                 q_ok;
    r    = '0;
    q_ok = (queue_sel < NUM_Q);
    case (acc.op)
      vmmio_pkg::OP_READ: begin
        r.access_ok = 1'b1;
        case (acc.offset)
          vmmio_pkg::OFF_MAGIC:         r.read_data = vmmio_pkg::MAGIC_VALUE;
          vmmio_pkg::OFF_VERSION:       r.read_data = vmmio_pkg::VERSION_VALUE;
          vmmio_pkg::OFF_DEVICE_ID:     r.read_data = dev_id_cfg;
          vmmio_pkg::OFF_VENDOR_ID:     r.read_data = vmmio_pkg::VENDOR_VALUE;
          vmmio_pkg::OFF_DEV_FEAT:      r.read_data = feat_sel ? feat_hi_cfg : feat_lo_cfg;
          vmmio_pkg::OFF_QUEUE_NUM_MAX: r.read_data = q_ok ? QSIZE_MAX : 32'd0;
          vmmio_pkg::OFF_QUEUE_READY:
            r.read_data = q_ok ? {31'd0, q_ready[queue_sel]} : 32'd0;
          vmmio_pkg::OFF_INT_STATUS:    r.read_data = irq_status;
          vmmio_pkg::OFF_STATUS:        r.read_data = dev_status;
          vmmio_pkg::OFF_CONFIG_GEN:    r.read_data = 32'd0;
          default:                      r.access_ok = 1'b0;
        endcase
      end
      vmmio_pkg::OP_WRITE: begin
        r.access_ok = 1'b1;
        case (acc.offset)
          vmmio_pkg::OFF_DEV_FEAT_SEL: feat_sel = acc.write_data[0];
          vmmio_pkg::OFF_QUEUE_SEL:    queue_sel = acc.write_data;
          vmmio_pkg::OFF_QUEUE_READY:
            if (q_ok) q_ready[queue_sel] = (acc.write_data == 32'd1);
          vmmio_pkg::OFF_QUEUE_NOTIFY: begin
            r.notify_valid = 1'b1;
            r.notify_queue = acc.write_data;
          end
          vmmio_pkg::OFF_INT_ACK:      irq_status &= ~acc.write_data;
          vmmio_pkg::OFF_STATUS: begin
            dev_status = acc.write_data;
            // status zero is a device reset: queues drop their ready flag
            if (acc.write_data == 32'd0) foreach (q_ready[i]) q_ready[i] = 1'b0;
          end
          vmmio_pkg::OFF_DRV_FEAT, vmmio_pkg::OFF_DRV_FEAT_SEL, vmmio_pkg::OFF_QUEUE_NUM,
          vmmio_pkg::OFF_DESC_LO, vmmio_pkg::OFF_DESC_HI, vmmio_pkg::OFF_AVAIL_LO,
          vmmio_pkg::OFF_AVAIL_HI, vmmio_pkg::OFF_USED_LO, vmmio_pkg::OFF_USED_HI: ;
          default:                     r.access_ok = 1'b0;
        endcase
      end
      vmmio_pkg::OP_EVENT: begin
        irq_status[0] = 1'b1;
        r.access_ok   = 1'b1;
      end
      default: ;
    endcase
    r.irq_level = (irq_status != 32'd0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input monitor: predict each accepted transaction in acceptance order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      expected_responses = {expected_responses, predict_register_access(in_data)};
  end

  task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Result checker: match each accepted result against the oldest prediction.
  always @(posedge clk) begin
    vmmio_pkg::out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_responses.size() == 0) begin
        $error("result transaction with no prediction pending");
        error_count++;
      end else begin
        exp_r = expected_responses.pop_front();
        compare_field("read_data",    exp_r.read_data,         out_data.read_data);
        compare_field("access_ok",    32'(exp_r.access_ok),    32'(out_data.access_ok));
        compare_field("irq_level",    32'(exp_r.irq_level),    32'(out_data.irq_level));
        compare_field("notify_valid", 32'(exp_r.notify_valid), 32'(out_data.notify_valid));
        compare_field("notify_queue", exp_r.notify_queue,      out_data.notify_queue);
      end
    end
  end

  // Receiver back-pressure: switch between free flow, sparse random stalls,
  // a dense periodic pattern and solid stall blocks.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = (stall_mode == 3) ? $urandom_range(2, 24) : $urandom_range(8, 64);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= (stall_tick % 4 != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks. All of them start and end at a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one transaction and hold it until accepted; valid stays high after
  // acceptance so bursts run back to back.
  task automatic send_access(logic [1:0] op, logic [11:0] offset, logic [31:0] wdata);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_data.op         <= op;
    in_data.offset     <= offset;
    in_data.write_data <= wdata;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic bus_read(logic [11:0] offset);
    send_access(vmmio_pkg::OP_READ, offset, $urandom);
  endtask

  task automatic bus_write(logic [11:0] offset, logic [31:0] wdata);
    send_access(vmmio_pkg::OP_WRITE, offset, wdata);
  endtask

  // Drop valid and wait for every predicted result, then let the pipe settle.
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    in_valid   <= 1'b0;
    burst_left = 0;
    while (expected_responses.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_responses.size() != 0) begin
      $error("%0d predicted results never arrived", expected_responses.size());
      error_count++;
      expected_responses.delete();
    end
    repeat (3) @(posedge clk);
  endtask

  // Write all three configuration registers; only called while idle.
  task automatic set_device_config(logic [31:0] dev_id, logic [31:0] lo, logic [31:0] hi);
    logic [31:0] vals [3];
    vals = '{dev_id, lo, hi};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= (i == 0) ? vmmio_pkg::CFG_DEVICE_ID :
                   (i == 1) ? vmmio_pkg::CFG_FEAT_LO : vmmio_pkg::CFG_FEAT_HI;
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    dev_id_cfg  = dev_id;
    feat_lo_cfg = lo;
    feat_hi_cfg = hi;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fixed identity registers and the two feature words under extreme settings.
  task automatic test_identity_registers();
    set_device_config(32'hFFFF_FFFF, 32'hAAAA_5555, 32'h0000_0000);
    bus_read(vmmio_pkg::OFF_MAGIC);
    bus_read(vmmio_pkg::OFF_VERSION);
    bus_read(vmmio_pkg::OFF_DEVICE_ID);
    bus_read(vmmio_pkg::OFF_VENDOR_ID);
    bus_read(vmmio_pkg::OFF_CONFIG_GEN);
    bus_read(vmmio_pkg::OFF_DEV_FEAT);
    bus_write(vmmio_pkg::OFF_DEV_FEAT_SEL, 32'hFFFF_FFFF);
    bus_read(vmmio_pkg::OFF_DEV_FEAT);
    wait_idle();
  endtask

  // Out-of-range queue select, an oversized queue size write and the ready-equals-one rule.
  task automatic test_queue_registers();
    bus_write(vmmio_pkg::OFF_QUEUE_SEL, 32'hFFFF_FFFF);
    bus_read(vmmio_pkg::OFF_QUEUE_NUM_MAX);
    bus_write(vmmio_pkg::OFF_QUEUE_READY, 32'd1);
    bus_write(vmmio_pkg::OFF_QUEUE_SEL, NUM_Q - 1);
    bus_write(vmmio_pkg::OFF_QUEUE_NUM, 32'hFFFF_FFFF);
    bus_write(vmmio_pkg::OFF_QUEUE_READY, 32'd2);
    bus_read(vmmio_pkg::OFF_QUEUE_READY);
    bus_write(vmmio_pkg::OFF_QUEUE_READY, 32'd1);
    bus_read(vmmio_pkg::OFF_QUEUE_READY);
    wait_idle();
  endtask

  // Completion interrupt, acknowledge, notify, device reset and rejected accesses.
  task automatic test_irq_status_and_errors();
    send_access(vmmio_pkg::OP_EVENT, 12'h000, 32'h0);
    bus_write(vmmio_pkg::OFF_INT_ACK, 32'hFFFF_FFFF);
    bus_write(vmmio_pkg::OFF_QUEUE_NOTIFY, 32'hFFFF_FFFF);
    bus_write(vmmio_pkg::OFF_STATUS, 32'd0);
    bus_read(vmmio_pkg::OFF_QUEUE_READY);
    bus_read(vmmio_pkg::OFF_DRV_FEAT);
    bus_write(vmmio_pkg::OFF_MAGIC, 32'h1234_5678);
    bus_read(12'h002);
    bus_read(12'h100);
    send_access(OP_RESERVED, 12'hFFF, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  // Mostly well-formed register traffic with random content, a share of
  // unaligned, config-area and illegal accesses, across several settings.
  task automatic test_random_traffic(int unsigned per_phase);
    logic [1:0]  op;
    logic [11:0] offset;
    logic [31:0] wdata;
    int unsigned pick;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_device_config(32'h0, 32'h0, 32'hFFFF_FFFF);
        1:       set_device_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        default: set_device_config($urandom, $urandom, $urandom);
      endcase
      repeat (per_phase) begin
        pick = $urandom_range(0, 99);
        op = (pick < 45) ? vmmio_pkg::OP_READ :
             (pick < 90) ? vmmio_pkg::OP_WRITE :
             (pick < 97) ? vmmio_pkg::OP_EVENT : OP_RESERVED;
        pick = $urandom_range(0, 99);
        if (pick < 85)      offset = reg_offsets[$urandom_range(0, 22)];
        else if (pick < 93) offset = {3'd0, 7'($urandom_range(0, 127)), 2'b00};
        else                offset = 12'($urandom_range(0, 4095));
        case ($urandom_range(0, 7))
          0, 1:    wdata = $urandom_range(0, 3);
          2:       wdata = 32'h0;
          3:       wdata = 32'hFFFF_FFFF;
          4:       wdata = $urandom_range(QSIZE_MAX - 4, QSIZE_MAX + 4);
          default: wdata = $urandom;
        endcase
        send_access(op, offset, wdata);
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests, then report.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_registers();
    test_queue_registers();
    test_irq_status_and_errors();
    test_random_traffic(150);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
